// ===== sv/bmd_pkg.sv =====
package bmd_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 15;

   localparam int DIM_W       = 9;
   localparam int RADIUS_W    = 4;
   localparam int SAMPLE_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int DIM_MAX_W   = 13;
   localparam int RAD_MAX_W   = 6;
   localparam int DISK_LIMIT  = 3;

   localparam logic [SAMPLE_W-1:0] FG_VALUE = 8'hFF;
   localparam logic [SAMPLE_W-1:0] BG_VALUE = 8'h00;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WIDTH,
      REG_HEIGHT,
      REG_RADIUS,
      REG_THRESHOLD
   } reg_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPUTE,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [RADIUS_W-1:0] radius;
      logic [SAMPLE_W-1:0] threshold;
   } cfg_type;

   // zero counts as one, anything above the maximum as the maximum
   function automatic logic [DIM_MAX_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                      input int max_v);
      logic [DIM_MAX_W-1:0] res;
      res = DIM_MAX_W'(v);
      if (v == '0) begin
         res = DIM_MAX_W'(1);
      end else if (int'(v) > max_v) begin
         res = DIM_MAX_W'(max_v);
      end
      return res;
   endfunction

   function automatic logic [RAD_MAX_W-1:0] clamp_radius(input logic [RADIUS_W-1:0] v,
                                                         input int max_v);
      logic [RAD_MAX_W-1:0] res;
      res = RAD_MAX_W'(v);
      if (int'(v) > max_v) begin
         res = RAD_MAX_W'(max_v);
      end
      return res;
   endfunction

endpackage

// ===== sv/bmd_scan.sv =====
module bmd_scan #(
   parameter int MAX_WIDTH  = bmd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmd_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = bmd_pkg::MAX_RADIUS_DEF,
   parameter int AW         = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  bmd_pkg::cfg_type              cfg,
   output logic [AW-1:0]                 mask_addr,
   input  logic [bmd_pkg::SAMPLE_W-1:0]  mask_data,
   output logic                          res_we,
   output logic [AW-1:0]                 res_addr,
   output logic [bmd_pkg::SAMPLE_W-1:0]  res_data,
   output logic                          done
);

   localparam int XW  = $clog2(MAX_WIDTH + 1);
   localparam int YW  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_RADIUS + 1);
   localparam int OW  = RW + 1;
   localparam int MW  = (XW > YW) ? ((XW > RW) ? XW : RW) : ((YW > RW) ? YW : RW);
   localparam int CW  = MW + 2;
   localparam int DW  = 2 * OW + 1;

   logic                run_ff;
   logic [XW-1:0]       x_ff;
   logic [YW-1:0]       y_ff;
   logic signed [OW-1:0] dx_ff;
   logic signed [OW-1:0] dy_ff;
   logic [AW-1:0]       pix_ff;
   logic [XW-1:0]       w_ff;
   logic [YW-1:0]       h_ff;
   logic [RW-1:0]       r_ff;
   logic                disk_ff;
   logic                pass_ff;
   logic [bmd_pkg::SAMPLE_W-1:0] thr_ff;

   logic                p1_valid_ff;
   logic                p1_ok_ff;
   logic                p1_end_ff;
   logic                p1_final_ff;
   logic [AW-1:0]       p1_pix_ff;
   logic                hit_ff;

   logic [RW-1:0]       r_in;
   logic signed [CW-1:0] sx;
   logic signed [CW-1:0] sy;
   logic [DW-1:0]       dist_sq;
   logic [DW-1:0]       r_sq;
   logic                tap_ok;
   logic                last_dx, last_dy, last_tap, last_x, last_y, last_pix;
   logic signed [OW-1:0] r_signed;
   logic                hit_now;

   assign r_in     = RW'(bmd_pkg::clamp_radius(cfg.radius, MAX_RADIUS));
   assign r_signed = $signed({1'b0, r_ff});

   assign sx = CW'(signed'({1'b0, x_ff})) + CW'(dx_ff);
   assign sy = CW'(signed'({1'b0, y_ff})) + CW'(dy_ff);

   assign dist_sq = DW'(dx_ff * dx_ff) + DW'(dy_ff * dy_ff);
   assign r_sq    = DW'(r_ff) * DW'(r_ff);

   assign tap_ok = (sx >= 0) && (sx < CW'(signed'({1'b0, w_ff})))
                && (sy >= 0) && (sy < CW'(signed'({1'b0, h_ff})))
                && (!disk_ff || (dist_sq <= r_sq));

   assign mask_addr = AW'(AW'(sy[YW-1:0]) * AW'(w_ff)) + AW'(sx[XW-1:0]);

   assign last_dx  = (dx_ff == r_signed);
   assign last_dy  = (dy_ff == r_signed);
   assign last_tap = last_dx && last_dy;
   assign last_x   = (x_ff == w_ff - XW'(1));
   assign last_y   = (y_ff == h_ff - YW'(1));
   assign last_pix = last_tap && last_x && last_y;

   // window taps go out one a cycle; the sample comes back in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && last_pix) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         w_ff    <= XW'(bmd_pkg::clamp_dim(cfg.width, MAX_WIDTH));
         h_ff    <= YW'(bmd_pkg::clamp_dim(cfg.height, MAX_HEIGHT));
         r_ff    <= r_in;
         disk_ff <= (int'(r_in) <= bmd_pkg::DISK_LIMIT);
         pass_ff <= (r_in == '0);
         thr_ff  <= cfg.threshold;
         x_ff    <= '0;
         y_ff    <= '0;
         pix_ff  <= '0;
         dx_ff   <= -$signed({1'b0, r_in});
         dy_ff   <= -$signed({1'b0, r_in});
      end else if (run_ff) begin
         if (!last_dx) begin
            dx_ff <= dx_ff + OW'(1);
         end else begin
            dx_ff <= -r_signed;
            if (!last_dy) begin
               dy_ff <= dy_ff + OW'(1);
            end else begin
               dy_ff  <= -r_signed;
               pix_ff <= pix_ff + AW'(1);
               if (!last_x) begin
                  x_ff <= x_ff + XW'(1);
               end else begin
                  x_ff <= '0;
                  y_ff <= y_ff + YW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= run_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ok_ff    <= tap_ok;
      p1_end_ff   <= last_tap;
      p1_final_ff <= last_pix;
      p1_pix_ff   <= pix_ff;
   end

   assign hit_now = hit_ff || (p1_ok_ff && (mask_data > thr_ff));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         hit_ff <= 1'b0;
      end else if (p1_valid_ff) begin
         hit_ff <= p1_end_ff ? 1'b0 : hit_now;
      end
   end

   assign res_we   = p1_valid_ff && p1_end_ff;
   assign res_addr = p1_pix_ff;
   assign res_data = pass_ff ? mask_data :
                     (hit_now ? bmd_pkg::FG_VALUE : bmd_pkg::BG_VALUE);
   assign done     = p1_valid_ff && p1_end_ff && p1_final_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(run_ff))
      else $error("scan done without a running pass");

   a_write_in_pass: assert property (@(posedge clock) disable iff (reset)
      res_we |-> p1_valid_ff && !start)
      else $error("result write outside a pass");

   a_run_stops: assert property (@(posedge clock) disable iff (reset)
      run_ff && last_pix && !start |=> !run_ff)
      else $error("pass did not stop at the final pixel");

endmodule

// ===== sv/binary_mask_dilation_unit.sv =====
// Binary mask dilation.
// Request channel (req_valid/req_stall): req_op selects a load or a read.
//   A load writes req_mask_sample at the next frame position (dropped once
//   the frame is full); req_last_sample closes the frame and starts the pass.
//   A read returns the next result pixel on the rsp channel, or nothing when
//   no computed frame is waiting.
// Loads are taken whenever the unit is idle. A read is a result memory read,
// then a load of the output register once that register is free.
// After the last sample the pass holds req_stall while the scan runs: one
// mask memory read per window tap, every tap of the window visited.
// Response channel (rsp_valid/rsp_stall) has an output register; loads go on
// being taken while a result waits, a further read waits until it drains.
// csr_valid/csr_ready writes width, height, radius and threshold by index;
// csr_ready is always high.
// Reset clears the positions, the ready flag and the response valid flag and
// sets the registers to their defaults; frame stores are not cleared.
module binary_mask_dilation_unit #(
   parameter int MAX_WIDTH  = bmd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmd_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = bmd_pkg::MAX_RADIUS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [bmd_pkg::SAMPLE_W-1:0]     req_mask_sample,
   input  logic                             req_last_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bmd_pkg::SAMPLE_W-1:0]     rsp_dilated_value,
   output logic                             rsp_last_pixel,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bmd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bmd_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW    = $clog2(CELLS + 1);

   bmd_pkg::state_type state_ff, state_in;
   bmd_pkg::cfg_type   cfg_ff;

   logic [PW-1:0] load_pos_ff;
   logic [AW-1:0] read_pos_ff;
   logic          frame_ready_ff;
   logic          pend_last_ff;
   logic          rsp_valid_ff;
   logic [bmd_pkg::SAMPLE_W-1:0] rsp_value_ff;
   logic          rsp_last_ff;

   logic [bmd_pkg::SAMPLE_W-1:0] mask_mem [CELLS];
   logic [bmd_pkg::SAMPLE_W-1:0] result_mem [CELLS];
   logic [bmd_pkg::SAMPLE_W-1:0] mask_rd_ff;
   logic [bmd_pkg::SAMPLE_W-1:0] res_rd_ff;

   logic [PW-1:0] frame_size;
   logic          accept;
   logic          is_load, is_read;
   logic          mask_we;
   logic          read_final;
   logic          scan_start;
   logic          rsp_load;
   logic          rsp_take;

   logic [AW-1:0]                 scan_mask_addr;
   logic                          scan_res_we;
   logic [AW-1:0]                 scan_res_addr;
   logic [bmd_pkg::SAMPLE_W-1:0]  scan_res_data;
   logic                          scan_done;

   assign frame_size = PW'(bmd_pkg::clamp_dim(cfg_ff.width, MAX_WIDTH))
                     * PW'(bmd_pkg::clamp_dim(cfg_ff.height, MAX_HEIGHT));

   assign accept     = req_valid && !req_stall;
   assign is_load    = accept && (req_op == bmd_pkg::OP_LOAD);
   assign is_read    = accept && (req_op == bmd_pkg::OP_READ) && frame_ready_ff;
   assign mask_we    = is_load && (load_pos_ff < frame_size);
   assign scan_start = is_load && req_last_sample;
   // a shrunk frame makes any read at or past the end the final one
   assign read_final = (PW'(read_pos_ff) + PW'(1)) >= frame_size;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      case (state_ff)
         bmd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (scan_start) begin
               state_in = bmd_pkg::ST_COMPUTE;
            end else if (is_read) begin
               state_in = bmd_pkg::ST_READ_OUT;
            end
         end
         bmd_pkg::ST_COMPUTE: begin
            if (scan_done) begin
               state_in = bmd_pkg::ST_IDLE;
            end
         end
         bmd_pkg::ST_READ_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = bmd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width     <= bmd_pkg::DIM_W'(256);
         cfg_ff.height    <= bmd_pkg::DIM_W'(256);
         cfg_ff.radius    <= '0;
         cfg_ff.threshold <= bmd_pkg::SAMPLE_W'(127);
      end else if (csr_valid && csr_ready) begin
         case (bmd_pkg::reg_index_type'(csr_index))
            bmd_pkg::REG_WIDTH:     cfg_ff.width     <= csr_wdata;
            bmd_pkg::REG_HEIGHT:    cfg_ff.height    <= csr_wdata;
            bmd_pkg::REG_RADIUS:    cfg_ff.radius    <= csr_wdata[bmd_pkg::RADIUS_W-1:0];
            bmd_pkg::REG_THRESHOLD: cfg_ff.threshold <= csr_wdata[bmd_pkg::SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff    <= '0;
         read_pos_ff    <= '0;
         frame_ready_ff <= 1'b0;
      end else begin
         if (scan_start) begin
            load_pos_ff <= '0;
            read_pos_ff <= '0;
         end else if (mask_we) begin
            load_pos_ff <= load_pos_ff + PW'(1);
         end
         if (is_read) begin
            read_pos_ff <= read_final ? '0 : read_pos_ff + AW'(1);
         end
         if (scan_done) begin
            frame_ready_ff <= 1'b1;
         end else if (is_read && read_final) begin
            frame_ready_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_read) begin
         pend_last_ff <= read_final;
      end
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[load_pos_ff[AW-1:0]] <= req_mask_sample;
      end
      mask_rd_ff <= mask_mem[scan_mask_addr];
   end

   // read port held outside idle so the fetched pixel stays put
   always_ff @(posedge clock) begin
      if (scan_res_we) begin
         result_mem[scan_res_addr] <= scan_res_data;
      end
      if (state_ff == bmd_pkg::ST_IDLE) begin
         res_rd_ff <= result_mem[read_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= res_rd_ff;
         rsp_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dilated_value = rsp_value_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   bmd_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS),
      .AW         (AW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .cfg       (cfg_ff),
      .mask_addr (scan_mask_addr),
      .mask_data (mask_rd_ff),
      .res_we    (scan_res_we),
      .res_addr  (scan_res_addr),
      .res_data  (scan_res_data),
      .done      (scan_done)
   );

   a_done_in_compute: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> state_ff == bmd_pkg::ST_COMPUTE)
      else $error("pass finished outside compute");

   a_no_load_in_pass: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmd_pkg::ST_COMPUTE |-> !mask_we && !is_read)
      else $error("item taken during the pass");

   a_readout_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == bmd_pkg::ST_IDLE)
      else $error("read result not presented");

   a_ready_set_by_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(frame_ready_ff) |-> $past(scan_done))
      else $error("frame ready without a finished pass");

endmodule
